// ===== hw/rtl/rle4pvd_pkg.sv =====
// Shared widths, codes and types of the 4-bit RLE palette viewport decoder.
package rle4pvd_pkg;

   localparam int unsigned WordW    = 16;
   localparam int unsigned ColorW   = 16;
   localparam int unsigned SlotW    = 4;
   localparam int unsigned DestXW   = 9;
   localparam int unsigned DestYW   = 8;
   localparam int unsigned StatusW  = 3;
   localparam int unsigned RunW     = 15;
   localparam int unsigned CsrAddrW = 5;
   localparam int unsigned CsrDataW = 32;

   localparam logic OP_FRAME_WORD    = 1'b0;
   localparam logic OP_PALETTE_WRITE = 1'b1;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [StatusW-1:0] {
      ST_OK          = 3'd0,
      ST_BAD_INDEX   = 3'd1,
      ST_TRUNCATED   = 3'd2,
      ST_SHORT_IMAGE = 3'd3,
      ST_SMALL_IMAGE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_CAMERA_X     = 3'd2,
      REG_CAMERA_Y     = 3'd3,
      REG_PALETTE_SIZE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              kind;
      logic [DestXW-1:0] dest_x;
      logic [DestYW-1:0] dest_y;
      logic [ColorW-1:0] color;
      logic [StatusW-1:0] status;
      logic              last;
   } result_type;

endpackage

// ===== hw/rtl/rle4pvd_req_if.sv =====
// Input channel: frame data words and palette writes.
interface rle4pvd_req_if;
   logic                              valid;
   logic                              ready;
   logic                              operation;
   logic [rle4pvd_pkg::WordW-1:0]     data_word;
   logic [rle4pvd_pkg::SlotW-1:0]     palette_slot;
   logic [rle4pvd_pkg::ColorW-1:0]    palette_color;
   logic                              last_word;

   modport source (
      output valid, operation, data_word, palette_slot, palette_color, last_word,
      input  ready
   );
   modport sink (
      input  valid, operation, data_word, palette_slot, palette_color, last_word,
      output ready
   );
endinterface

// ===== hw/rtl/rle4pvd_rsp_if.sv =====
// Result channel: visible pixels and end-of-frame status words.
interface rle4pvd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [rle4pvd_pkg::DestXW-1:0]     dest_x;
   logic [rle4pvd_pkg::DestYW-1:0]     dest_y;
   logic [rle4pvd_pkg::ColorW-1:0]     color;
   logic [rle4pvd_pkg::StatusW-1:0]    status;
   logic                               last;

   modport source (
      output valid, kind, dest_x, dest_y, color, status, last,
      input  ready
   );
   modport sink (
      input  valid, kind, dest_x, dest_y, color, status, last,
      output ready
   );
endinterface

// ===== hw/rtl/rle4_palette_viewport_decoder_top.sv =====
// Top level of the 4-bit RLE palette viewport decoder, with its register port.
//
// Decodes one frame's run-length stream of 4-bit palette indices and emits the colour
// of every pixel inside the VIEW_W x VIEW_H viewport, closing the frame with a status
// word. One input word is handled at a time by a small sequencer; the next word is
// taken once the last result of the current one sits in the output register. A
// palette write is done in the idle state. A zero-length header, or a word after
// the frame is full, passes through S_END and S_FLUSH; a literal header also goes
// through S_MUL and S_CLAMP for its 16x16 room multiply and clamp compare. A literal
// data word steps its n pixels (n up to 4) through S_PIX, one pixel per cycle through
// the viewport compare and palette read while no visible pixel is held back. A skip
// header goes through S_SKIP, the skip unit wrapping one row per cycle. A status word
// adds S_STATUS. S_PIX, S_STATUS and S_FLUSH hold while the result side is stalled.
module rle4_palette_viewport_decoder_top #(
   parameter int unsigned VIEW_W = 320,
   parameter int unsigned VIEW_H = 240
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rle4pvd_req_if.sink                          req_ch,
   rle4pvd_rsp_if.source                        rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rle4pvd_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [rle4pvd_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [rle4pvd_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam logic [15:0] ViewW = 16'(VIEW_W);
   localparam logic [15:0] ViewH = 16'(VIEW_H);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MUL    = 8'b0000_0010,
      S_CLAMP  = 8'b0000_0100,
      S_SKIP   = 8'b0000_1000,
      S_PIX    = 8'b0001_0000,
      S_END    = 8'b0010_0000,
      S_STATUS = 8'b0100_0000,
      S_FLUSH  = 8'b1000_0000
   } seq_state_type;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_LITERAL = 4'b0010,
      PH_DONE    = 4'b0100,
      PH_ERROR   = 4'b1000
   } phase_type;

   // configuration
   logic [15:0] frame_width_ff, frame_height_ff, camera_x_ff, camera_y_ff;
   logic [4:0]  palette_size_ff;
   logic [2:0]  csr_index;
   logic        csr_write;

   // sequencer and decode state
   seq_state_type           state_ff, state_in;
   phase_type               phase_ff, phase_in;
   logic [13:0]             words_left_ff, words_left_in;
   logic [14:0]             pixels_left_ff, pixels_left_in;
   logic [15:0]             column_ff, column_in;
   logic [15:0]             row_ff, row_in;
   logic [15:0]             word_ff, word_in;
   logic                    last_ff, last_in;
   logic [14:0]             run_ff, run_in;
   logic [2:0]              lane_ff, lane_in;
   rle4pvd_pkg::status_type status_ff, status_in;
   logic [31:0]             prod_ff, prod_in;
   logic                    room_ok_ff, room_ok_in;

   logic [rle4pvd_pkg::ColorW-1:0] palette_ff [16];

   // staging word and output register
   rle4pvd_pkg::result_type pend_ff, pend_in, out_ff, out_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    out_valid_ff, out_valid_in;

   // shared datapath
   logic        req_take;
   logic        out_free, can_gen;
   logic        gen_valid;
   rle4pvd_pkg::result_type gen_res;
   logic [3:0]  idx;
   logic [16:0] dx, dy;
   logic        vis;
   logic [15:0] room;
   logic [15:0] col_inc;
   logic [15:0] rows_left;
   logic [31:0] rest;
   logic        small_image;
   logic [14:0] req_run;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 16'd320;
         frame_height_ff <= 16'd240;
         camera_x_ff     <= 16'd0;
         camera_y_ff     <= 16'd0;
         palette_size_ff <= 5'd16;
      end else if (csr_write) begin
         case (csr_index)
            rle4pvd_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[15:0];
            rle4pvd_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[15:0];
            rle4pvd_pkg::REG_CAMERA_X:     camera_x_ff     <= csr_pwdata[15:0];
            rle4pvd_pkg::REG_CAMERA_Y:     camera_y_ff     <= csr_pwdata[15:0];
            rle4pvd_pkg::REG_PALETTE_SIZE: palette_size_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rle4pvd_pkg::REG_FRAME_WIDTH:  csr_prdata = 32'(frame_width_ff);
         rle4pvd_pkg::REG_FRAME_HEIGHT: csr_prdata = 32'(frame_height_ff);
         rle4pvd_pkg::REG_CAMERA_X:     csr_prdata = 32'(camera_x_ff);
         rle4pvd_pkg::REG_CAMERA_Y:     csr_prdata = 32'(camera_y_ff);
         rle4pvd_pkg::REG_PALETTE_SIZE: csr_prdata = 32'(palette_size_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   // ---------------- palette ----------------
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (req_take && (req_ch.operation == rle4pvd_pkg::OP_PALETTE_WRITE)) begin
         palette_ff[req_ch.palette_slot] <= req_ch.palette_color;
      end
   end

   // ---------------- datapath ----------------
   assign idx       = 4'(word_ff >> {lane_ff[1:0], 2'b00});
   assign dx        = {1'b0, column_ff} - {1'b0, camera_x_ff};
   assign dy        = {1'b0, row_ff} - {1'b0, camera_y_ff};
   assign vis       = !dx[16] && (dx[15:0] < ViewW) && !dy[16] && (dy[15:0] < ViewH);
   assign room      = frame_width_ff - column_ff;
   assign col_inc   = column_ff + 16'd1;
   assign rows_left = frame_height_ff - row_ff;
   assign rest      = room_ok_ff ? (prod_ff - 32'(column_ff)) : 32'd0;
   assign small_image = (frame_width_ff < ViewW) || (frame_height_ff < ViewH);
   assign req_run   = req_ch.data_word[rle4pvd_pkg::RunW-1:0];

   // a result may enter staging when staging is empty or can move to the output
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign can_gen  = !pend_valid_ff || out_free;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      words_left_in  = words_left_ff;
      pixels_left_in = pixels_left_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      word_in        = word_ff;
      last_in        = last_ff;
      run_in         = run_ff;
      lane_in        = lane_ff;
      status_in      = status_ff;
      prod_in        = prod_ff;
      room_ok_in     = room_ok_ff;
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff && !rsp_ch.ready;
      gen_valid      = 1'b0;
      gen_res        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               word_in = req_ch.data_word;
               last_in = req_ch.last_word;
               if (req_ch.operation == rle4pvd_pkg::OP_PALETTE_WRITE) begin
                  state_in = S_IDLE;
               end else if (phase_ff == PH_ERROR) begin
                  // dropped word; a last word rearms without a result
                  if (req_ch.last_word) begin
                     phase_in       = PH_HEADER;
                     words_left_in  = '0;
                     pixels_left_in = '0;
                     column_in      = '0;
                     row_in         = '0;
                  end
               end else if (small_image) begin
                  status_in = rle4pvd_pkg::ST_SMALL_IMAGE;
                  state_in  = S_STATUS;
               end else if (phase_ff == PH_HEADER) begin
                  run_in = req_run;
                  if (req_run == '0) begin
                     state_in = S_END;
                  end else if (req_ch.data_word[15]) begin
                     state_in = S_SKIP;
                  end else begin
                     words_left_in = 14'((17'(req_run) + 17'd3) >> 2);
                     state_in      = S_MUL;
                  end
               end else if (phase_ff == PH_LITERAL) begin
                  lane_in  = '0;
                  state_in = S_PIX;
               end else begin
                  state_in = S_END;
               end
            end
         end

         S_SKIP: begin
            if ((run_ff == '0) || (row_ff >= frame_height_ff)) begin
               if (row_ff >= frame_height_ff) begin
                  phase_in = PH_DONE;
               end
               state_in = S_END;
            end else if (column_ff >= frame_width_ff) begin
               column_in = '0;
               row_in    = row_ff + 16'd1;
            end else if ({1'b0, run_ff} >= room) begin
               // run reaches the row end
               run_in    = 15'({1'b0, run_ff} - room);
               column_in = '0;
               row_in    = row_ff + 16'd1;
            end else begin
               column_in = column_ff + 16'(run_ff);
               run_in    = '0;
            end
         end

         S_MUL: begin
            prod_in    = 32'(rows_left) * 32'(frame_width_ff);
            room_ok_in = (row_ff < frame_height_ff) && (column_ff < frame_width_ff);
            state_in   = S_CLAMP;
         end

         S_CLAMP: begin
            pixels_left_in = (rest < 32'(run_ff)) ? 15'(rest) : run_ff;
            phase_in       = PH_LITERAL;
            state_in       = S_END;
         end

         S_PIX: begin
            if ((pixels_left_ff == '0) || (lane_ff == 3'd4)) begin
               words_left_in = words_left_ff - 14'd1;
               if (words_left_ff == 14'd1) begin
                  phase_in = (row_ff >= frame_height_ff) ? PH_DONE : PH_HEADER;
               end
               state_in = S_END;
            end else if (vis && ({1'b0, idx} >= palette_size_ff)) begin
               status_in = rle4pvd_pkg::ST_BAD_INDEX;
               state_in  = S_STATUS;
            end else begin
               if (vis) begin
                  gen_valid      = 1'b1;
                  gen_res.kind   = rle4pvd_pkg::KIND_PIXEL;
                  gen_res.dest_x = dx[rle4pvd_pkg::DestXW-1:0];
                  gen_res.dest_y = dy[rle4pvd_pkg::DestYW-1:0];
                  gen_res.color  = palette_ff[idx];
                  gen_res.status = rle4pvd_pkg::ST_OK;
               end
               if (!vis || can_gen) begin
                  pixels_left_in = pixels_left_ff - 15'd1;
                  lane_in        = lane_ff + 3'd1;
                  if (col_inc >= frame_width_ff) begin
                     column_in = '0;
                     row_in    = row_ff + 16'd1;
                  end else begin
                     column_in = col_inc;
                  end
               end
            end
         end

         S_END: begin
            if (last_ff) begin
               if (phase_ff == PH_LITERAL) begin
                  status_in = rle4pvd_pkg::ST_TRUNCATED;
               end else if (row_ff >= frame_height_ff) begin
                  status_in = rle4pvd_pkg::ST_OK;
               end else begin
                  status_in = rle4pvd_pkg::ST_SHORT_IMAGE;
               end
               state_in = S_STATUS;
            end else begin
               state_in = S_FLUSH;
            end
         end

         S_STATUS: begin
            gen_valid      = 1'b1;
            gen_res.kind   = rle4pvd_pkg::KIND_STATUS;
            gen_res.status = status_ff;
            if (can_gen) begin
               phase_in       = last_ff ? PH_HEADER : PH_ERROR;
               words_left_in  = '0;
               pixels_left_in = '0;
               column_in      = '0;
               row_in         = '0;
               state_in       = S_FLUSH;
            end
         end

         S_FLUSH: begin
            // staged word is the last result of this input
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (gen_valid && can_gen) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_valid_in = 1'b1;
         end
         pend_in       = gen_res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         phase_ff       <= PH_HEADER;
         words_left_ff  <= '0;
         pixels_left_ff <= '0;
         column_ff      <= '0;
         row_ff         <= '0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         words_left_ff  <= words_left_in;
         pixels_left_ff <= pixels_left_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      last_ff    <= last_in;
      run_ff     <= run_in;
      lane_ff    <= lane_in;
      status_ff  <= status_in;
      prod_ff    <= prod_in;
      room_ok_ff <= room_ok_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.kind   = out_ff.kind;
   assign rsp_ch.dest_x = out_ff.dest_x;
   assign rsp_ch.dest_y = out_ff.dest_y;
   assign rsp_ch.color  = out_ff.color;
   assign rsp_ch.status = out_ff.status;
   assign rsp_ch.last   = out_ff.last;

`ifndef SYNTHESIS
   a_literal_has_words: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LITERAL) |-> (words_left_ff != '0))
      else $error("literal phase with no words left");

   a_idle_nothing_staged: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("result still staged while taking a new word");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.kind == rle4pvd_pkg::KIND_STATUS)) |-> rsp_ch.last)
      else $error("status word not marked last");

   a_pixel_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.kind == rle4pvd_pkg::KIND_PIXEL))
         |-> (rsp_ch.status == rle4pvd_pkg::ST_OK))
      else $error("pixel word with a non-zero status");

   a_skip_progress: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SKIP) && (run_ff != '0) && (row_ff < frame_height_ff))
         |=> ((row_ff != $past(row_ff)) || (run_ff != $past(run_ff))))
      else $error("skip unit made no progress");
`endif

endmodule

// ===== bench/rle4pvd_checker.sv =====
// Checker: snoops the register port and both channels, predicts the decoded words, compares.
module rle4pvd_checker #(
   parameter int unsigned VIEW_W = 320,
   parameter int unsigned VIEW_H = 240
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rle4pvd_req_if                               req_ch,
   rle4pvd_rsp_if                               rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic                                 csr_pready,
   input  logic [rle4pvd_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [rle4pvd_pkg::CsrDataW-1:0]     csr_pwdata,
   output int unsigned                          mismatch_count,
   output int unsigned                          results_due
);

   typedef enum logic [1:0] {
      DEC_HEADER,
      DEC_LITERAL,
      DEC_DONE,
      DEC_ERROR
   } decode_phase_type;

   // register copies
   int unsigned width_q, height_q, cam_x_q, cam_y_q, pal_size_q;
   // decoder state
   decode_phase_type phase_q;
   int unsigned      words_left, pixels_left, col_q, row_q;
   logic [rle4pvd_pkg::ColorW-1:0] palette_q [16];

   rle4pvd_pkg::result_type decoded_words [$];

   function automatic string describe(rle4pvd_pkg::result_type r);
      return $sformatf("kind=%0d x=%0d y=%0d colour=%h status=%0d last=%0d",
                       r.kind, r.dest_x, r.dest_y, r.color, r.status, r.last);
   endfunction

   function automatic void emit(logic kind, int unsigned x, int unsigned y,
                                logic [rle4pvd_pkg::ColorW-1:0] colour,
                                rle4pvd_pkg::status_type st);
      rle4pvd_pkg::result_type r;
      r.kind   = kind;
      r.dest_x = x[rle4pvd_pkg::DestXW-1:0];
      r.dest_y = y[rle4pvd_pkg::DestYW-1:0];
      r.color  = colour;
      r.status = st;
      r.last   = 1'b0;
      decoded_words.push_back(r);
   endfunction

   task automatic rearm();
      phase_q     = DEC_HEADER;
      words_left  = 0;
      pixels_left = 0;
      col_q       = 0;
      row_q       = 0;
   endtask

   task automatic close_frame(input rle4pvd_pkg::status_type st, input logic last);
      emit(rle4pvd_pkg::KIND_STATUS, 0, 0, '0, st);
      rearm();
      if (!last) phase_q = DEC_ERROR;
   endtask

   task automatic advance_col();
      col_q = (col_q + 1) & 32'hFFFF;
      if (col_q >= width_q) begin
         col_q = 0;
         row_q = (row_q + 1) & 32'hFFFF;
      end
   endtask

   // transparent run, wrapping whole rows against the frame width
   task automatic skip_pixels(input int unsigned run);
      int unsigned step;
      while (run > 0 && row_q < height_q) begin
         if (col_q >= width_q) begin
            col_q = 0;
            row_q++;
         end else begin
            step = width_q - col_q;
            if (step > run) step = run;
            col_q += step;
            run   -= step;
            if (col_q >= width_q) begin
               col_q = 0;
               row_q++;
            end
         end
      end
   endtask

   task automatic decode_word(input logic op, input logic [rle4pvd_pkg::WordW-1:0] w,
                              input logic [rle4pvd_pkg::SlotW-1:0] slot,
                              input logic [rle4pvd_pkg::ColorW-1:0] colour,
                              input logic last);
      int unsigned              base, run, idx;
      longint unsigned          room;
      rle4pvd_pkg::status_type  st;
      bit                       index_fault;
      rle4pvd_pkg::result_type  tail;
      base        = decoded_words.size();
      index_fault = 1'b0;
      if (op == rle4pvd_pkg::OP_PALETTE_WRITE) begin
         palette_q[slot] = colour;
      end else if (phase_q == DEC_ERROR) begin
         if (last) rearm();
      end else if (width_q < VIEW_W || height_q < VIEW_H) begin
         close_frame(rle4pvd_pkg::ST_SMALL_IMAGE, last);
      end else begin
         case (phase_q)
            DEC_HEADER: begin
               run = w & 32'h7FFF;
               if (run != 0) begin
                  if (w[15]) begin
                     skip_pixels(run);
                     if (row_q >= height_q) phase_q = DEC_DONE;
                  end else begin
                     room = 0;
                     if (row_q < height_q && col_q < width_q) begin
                        room = height_q - row_q;
                        room = room * width_q - col_q;
                     end
                     words_left  = (run + 3) >> 2;
                     pixels_left = (room < run) ? room[31:0] : run;
                     phase_q     = DEC_LITERAL;
                  end
               end
            end
            DEC_LITERAL: begin
               for (int i = 0; i < 4 && pixels_left > 0 && !index_fault; i++) begin
                  idx = (w >> (4 * i)) & 32'hF;
                  if (col_q >= cam_x_q && col_q - cam_x_q < VIEW_W &&
                      row_q >= cam_y_q && row_q - cam_y_q < VIEW_H) begin
                     if (idx >= pal_size_q) begin
                        close_frame(rle4pvd_pkg::ST_BAD_INDEX, last);
                        index_fault = 1'b1;
                     end else begin
                        emit(rle4pvd_pkg::KIND_PIXEL, col_q - cam_x_q, row_q - cam_y_q,
                             palette_q[idx[3:0]], rle4pvd_pkg::ST_OK);
                     end
                  end
                  if (!index_fault) begin
                     pixels_left--;
                     advance_col();
                  end
               end
               if (!index_fault) begin
                  words_left--;
                  if (words_left == 0) phase_q = (row_q >= height_q) ? DEC_DONE : DEC_HEADER;
               end
            end
            default: ;
         endcase
         if (last && !index_fault) begin
            if (phase_q == DEC_LITERAL) st = rle4pvd_pkg::ST_TRUNCATED;
            else st = (row_q >= height_q) ? rle4pvd_pkg::ST_OK : rle4pvd_pkg::ST_SHORT_IMAGE;
            close_frame(st, 1'b1);
         end
      end
      if (decoded_words.size() > base) begin
         tail = decoded_words[decoded_words.size() - 1];
         tail.last = 1'b1;
         decoded_words[decoded_words.size() - 1] = tail;
      end
   endtask

   always @(posedge clock) begin : monitor
      rle4pvd_pkg::result_type got, want;
      if (reset) begin
         width_q    = 320;
         height_q   = 240;
         cam_x_q    = 0;
         cam_y_q    = 0;
         pal_size_q = 16;
         rearm();
         palette_q  = '{default: '0};
         decoded_words.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (rle4pvd_pkg::csr_index_type'(csr_paddr[rle4pvd_pkg::CsrAddrW-1:2]))
               rle4pvd_pkg::REG_FRAME_WIDTH:  width_q    = 32'(csr_pwdata[15:0]);
               rle4pvd_pkg::REG_FRAME_HEIGHT: height_q   = 32'(csr_pwdata[15:0]);
               rle4pvd_pkg::REG_CAMERA_X:     cam_x_q    = 32'(csr_pwdata[15:0]);
               rle4pvd_pkg::REG_CAMERA_Y:     cam_y_q    = 32'(csr_pwdata[15:0]);
               rle4pvd_pkg::REG_PALETTE_SIZE: pal_size_q = 32'(csr_pwdata[4:0]);
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            decode_word(req_ch.operation, req_ch.data_word, req_ch.palette_slot,
                        req_ch.palette_color, req_ch.last_word);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind   = rsp_ch.kind;
            got.dest_x = rsp_ch.dest_x;
            got.dest_y = rsp_ch.dest_y;
            got.color  = rsp_ch.color;
            got.status = rsp_ch.status;
            got.last   = rsp_ch.last;
            if (decoded_words.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected nothing, got %s", $time, describe(got));
            end else begin
               want = decoded_words.pop_front();
               if (got.kind !== want.kind || got.dest_x !== want.dest_x ||
                   got.dest_y !== want.dest_y || got.color !== want.color ||
                   got.status !== want.status || got.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: expected %s, got %s", $time, describe(want),
                           describe(got));
               end
            end
         end
      end
      results_due = decoded_words.size();
   end

endmodule

// ===== bench/rle4_palette_viewport_decoder_top_tb.sv =====
// Testbench top: clock, reset, register writes, word stimulus and the final verdict.
module rle4_palette_viewport_decoder_top_tb;

   localparam int unsigned VIEW_W        = 320;
   localparam int unsigned VIEW_H        = 240;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 150;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned MAX_SKIP      = 32767;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 csr_psel, csr_penable, csr_pwrite;
   logic [rle4pvd_pkg::CsrAddrW-1:0]     csr_paddr;
   logic [rle4pvd_pkg::CsrDataW-1:0]     csr_pwdata, csr_prdata;
   logic                                 csr_pready;

   int unsigned mismatches, results_due, cycle_count, words_sent;
   int unsigned sender_idle_pct, receiver_idle_pct, hold_request;
   int unsigned set_width, set_height, set_pal_size;

   rle4pvd_req_if req_bus ();
   rle4pvd_rsp_if rsp_bus ();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rle4_palette_viewport_decoder_top #(
      .VIEW_W (VIEW_W),
      .VIEW_H (VIEW_H)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rle4pvd_checker #(
      .VIEW_W (VIEW_W),
      .VIEW_H (VIEW_H)
   ) result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatches),
      .results_due    (results_due)
   );

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   task automatic send_word(input logic op, input logic [rle4pvd_pkg::WordW-1:0] word,
                            input logic [rle4pvd_pkg::SlotW-1:0] slot,
                            input logic [rle4pvd_pkg::ColorW-1:0] colour,
                            input logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.data_word     <= word;
      req_bus.palette_slot  <= slot;
      req_bus.palette_color <= colour;
      req_bus.last_word     <= last;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   task automatic send_data(input logic [rle4pvd_pkg::WordW-1:0] word, input logic last);
      send_word(rle4pvd_pkg::OP_FRAME_WORD, word, 4'($urandom_range(0, 15)),
                16'($urandom_range(0, 16'hFFFF)), last);
   endtask

   task automatic send_palette(input logic [rle4pvd_pkg::SlotW-1:0] slot,
                               input logic [rle4pvd_pkg::ColorW-1:0] colour,
                               input logic last);
      send_word(rle4pvd_pkg::OP_PALETTE_WRITE, 16'($urandom_range(0, 16'hFFFF)), slot,
                colour, last);
   endtask

   task automatic csr_write(input rle4pvd_pkg::csr_index_type idx,
                            input logic [rle4pvd_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drain every due word, then let a word with no result finish
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input int unsigned fw, input int unsigned fh,
                                input int unsigned cx, input int unsigned cy,
                                input int unsigned ps);
      wait_idle();
      csr_write(rle4pvd_pkg::REG_FRAME_WIDTH, fw);
      csr_write(rle4pvd_pkg::REG_FRAME_HEIGHT, fh);
      csr_write(rle4pvd_pkg::REG_CAMERA_X, cx);
      csr_write(rle4pvd_pkg::REG_CAMERA_Y, cy);
      csr_write(rle4pvd_pkg::REG_PALETTE_SIZE, ps);
      set_width    = fw;
      set_height   = fh;
      set_pal_size = ps;
   endtask

   // mostly in-range indices, now and then a bad one
   function automatic logic [3:0] pick_index();
      if ($urandom_range(0, 99) < 92) return 4'($urandom_range(0, set_pal_size - 1));
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [rle4pvd_pkg::WordW-1:0] index_word();
      return {pick_index(), pick_index(), pick_index(), pick_index()};
   endfunction

   task automatic send_frame();
      int unsigned segs, pick, run, n_words, fills;
      segs = $urandom_range(1, 6);
      repeat (segs) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_data(16'($urandom_range(0, 16'hFFFF)), 1'b0);
         end else if (pick < 14) begin
            send_data($urandom_range(0, 1) ? 16'h8000 : 16'h0000, 1'b0);
         end else if (pick < 20) begin
            send_palette(4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
                         1'($urandom_range(0, 1)));
         end else if (pick < 45) begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_SKIP)
                                              : $urandom_range(1, 700);
            send_data({1'b1, run[14:0]}, 1'b0);
         end else begin
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(17, MAX_SKIP)
                                               : $urandom_range(1, 16);
            send_data({1'b0, run[14:0]}, 1'b0);
            n_words = (run + 3) / 4;
            // long runs are left open and run into whatever follows
            if (n_words > 4) n_words = $urandom_range(1, 4);
            repeat (n_words) send_data(index_word(), 1'b0);
         end
      end
      if ($urandom_range(0, 99) < 45) begin
         fills = (set_width * set_height + MAX_SKIP - 1) / MAX_SKIP;
         if (fills > 4) fills = 4;
         repeat (fills) send_data(16'hFFFF, 1'b0);
      end
      run = $urandom_range(0, 700);
      case ($urandom_range(0, 3))
         0:       send_data(index_word(), 1'b1);
         1:       send_data({1'b1, run[14:0]}, 1'b1);
         2:       send_data(16'($urandom_range(0, 16'hFFFF)), 1'b1);
         default: send_data(16'h0000, 1'b1);
      endcase
   endtask

   task automatic run_phase(input int unsigned fw, input int unsigned fh,
                            input int unsigned cx, input int unsigned cy,
                            input int unsigned ps, input int unsigned count,
                            input int unsigned send_pct, input int unsigned recv_pct,
                            input bit hold);
      int unsigned start;
      bit          hold_pending;
      apply_setting(fw, fh, cx, cy, ps);
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      hold_pending      = hold;
      start             = words_sent;
      while (words_sent - start < count) begin
         if (hold_pending && words_sent - start >= 15) begin
            hold_request = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         send_frame();
      end
   endtask

   initial begin : stimulus
      reset                 = 1'b1;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      req_bus.valid         = 1'b0;
      req_bus.operation     = rle4pvd_pkg::OP_FRAME_WORD;
      req_bus.data_word     = '0;
      req_bus.palette_slot  = '0;
      req_bus.palette_color = '0;
      req_bus.last_word     = 1'b0;
      words_sent            = 0;
      hold_request          = 0;
      sender_idle_pct       = 12;
      receiver_idle_pct     = 59;
      set_width             = 320;
      set_height            = 240;
      set_pal_size          = 16;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset setting, only slots 0, 5 and 15 read
      send_palette(4'd0, 16'h0000, 1'b0);
      send_palette(4'd15, 16'hFFFF, 1'b1);
      send_palette(4'd5, 16'hA5A5, 1'b0);
      send_data(16'h0000, 1'b0);
      send_data(16'h8000, 1'b0);
      send_data(16'h0006, 1'b0);
      send_data(16'hF50F, 1'b0);
      send_data(16'h0050, 1'b0);
      repeat (3) send_data(16'hFFFF, 1'b0);
      send_data(16'hFFFF, 1'b1);            // frame already full
      send_data(16'h0008, 1'b0);
      send_data(16'h5F05, 1'b1);            // four pixels then truncated run
      send_data(16'h8010, 1'b1);            // short image
      send_data(16'h7FFF, 1'b0);            // longest literal run
      send_data(16'h0000, 1'b0);
      send_data(16'hFFFF, 1'b1);
      apply_setting(320, 240, 0, 0, 5);     // bad index, then words dropped till last
      send_data(16'h0002, 1'b0);
      send_data(16'h0F50, 1'b0);
      send_data(16'h1234, 1'b0);
      send_data(16'h0000, 1'b1);
      apply_setting(1, 240, 0, 0, 16);      // image narrower than the view
      send_data(16'h0001, 1'b0);
      send_data(16'h0001, 1'b1);

      for (int slot = 0; slot < 16; slot++)
         send_palette(4'(slot), 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));

      run_phase(400, 300, 80, 60, 16, 60, 12, 59, 1'b1);
      run_phase(320, 240, 0, 0, 1, 45, 12, 59, 1'b0);
      run_phase(65535, 65535, 65535, 65535, 7, 35, 59, 12, 1'b0);
      run_phase(65535, 65535, 0, 0, 16, 45, 59, 12, 1'b0);
      run_phase(320, 1, 0, 0, 16, 25, 59, 12, 1'b0);
      run_phase(500, 250, 300, 100, 12, 60, 0, 0, 1'b0);
      run_phase(320, 240, 0, 0, 16, 60, 0, 0, 1'b0);
      wait_idle();

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
